// ----- hw/rtl/gmo_pkg.sv -----
// Shared constants, types and codes of the grayscale 3x3 opening engine.
package gmo_pkg;

  localparam int unsigned MAX_WIDTH   = 256;
  localparam int unsigned MAX_HEIGHT  = 256;
  localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned DIM_W  = 9;
  localparam int unsigned PASS_W = 4;
  localparam int unsigned SIZE_W = 2 * DIM_W;
  localparam int unsigned XW     = $clog2(MAX_WIDTH);
  localparam int unsigned YW     = $clog2(MAX_HEIGHT);

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  localparam logic [DIM_W-1:0] DIM_LIMIT_W = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] DIM_LIMIT_H = DIM_W'(MAX_HEIGHT);
  localparam logic [PIX_W-1:0] PIX_FULL    = '1;
  localparam logic [PIX_W-1:0] PIX_ZERO    = '0;

  // command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_ERODE_PASSES  = 2'd2;
  localparam logic [1:0] REG_DILATE_PASSES = 2'd3;

  // window tap codes along one axis
  localparam logic [1:0] TAP_LO  = 2'd0;
  localparam logic [1:0] TAP_MID = 2'd1;
  localparam logic [1:0] TAP_HI  = 2'd2;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ADDR_W-1:0] pixel_index;
    logic [PIX_W-1:0]  write_value;
  } gmo_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] read_value;
    logic             status;
  } gmo_result_t;

  typedef struct packed {
    logic [DIM_W-1:0]  frame_width;
    logic [DIM_W-1:0]  frame_height;
    logic [PASS_W-1:0] erode_passes;
    logic [PASS_W-1:0] dilate_passes;
  } gmo_cfg_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [PIX_W-1:0]  wdata;
  } gmo_mem_req_t;

  typedef struct packed {
    logic busy;
    logic pass_done;
    logic run_done;
  } gmo_eng_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_WRITE
  } gmo_state_e;

endpackage

// ----- hw/rtl/gmo_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module gmo_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/gmo_regs.sv -----
// APB configuration registers of the opening engine.
module gmo_regs import gmo_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output gmo_cfg_t          cfg_o
);

  gmo_cfg_t   cfg_q, cfg_d;
  logic [1:0] reg_sel;
  logic       wr_en;

  assign reg_sel = paddr[APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_FRAME_WIDTH:   cfg_d.frame_width   = pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT:  cfg_d.frame_height  = pwdata[DIM_W-1:0];
        REG_ERODE_PASSES:  cfg_d.erode_passes  = pwdata[PASS_W-1:0];
        REG_DILATE_PASSES: cfg_d.dilate_passes = pwdata[PASS_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width   <= DIM_LIMIT_W;
      cfg_q.frame_height  <= DIM_LIMIT_H;
      cfg_q.erode_passes  <= '0;
      cfg_q.dilate_passes <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FRAME_WIDTH:   prdata = APB_DW'(cfg_q.frame_width);
      REG_FRAME_HEIGHT:  prdata = APB_DW'(cfg_q.frame_height);
      REG_ERODE_PASSES:  prdata = APB_DW'(cfg_q.erode_passes);
      REG_DILATE_PASSES: prdata = APB_DW'(cfg_q.dilate_passes);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/gmo_engine.sv -----
// Pass sequencer: walks the frame, fetches the nine window taps and folds them
// through one min/max comparator, then writes the result to the other store.
module gmo_engine import gmo_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PASS_W-1:0] erode_passes_i,
  input  logic [PASS_W-1:0] dilate_passes_i,
  input  logic [DIM_W-1:0]  width_i,
  input  logic [DIM_W-1:0]  height_i,
  input  logic [PIX_W-1:0]  src_rdata_i,
  output gmo_mem_req_t      req_o,
  output gmo_eng_stat_t     stat_o
);

  gmo_state_e        state_q, state_d;
  logic [XW-1:0]     x_q, x_d;
  logic [YW-1:0]     y_q, y_d;
  logic [ADDR_W-1:0] row_q, row_d;
  logic [1:0]        dx_q, dx_d, dy_q, dy_d;
  logic [PIX_W-1:0]  acc_q, acc_d;
  logic              tapv_q, tapv_d;
  logic [PASS_W-1:0] erode_left_q, erode_left_d;
  logic [PASS_W-1:0] dilate_left_q, dilate_left_d;

  logic [ADDR_W-1:0] w16, row_sel, tap_addr;
  logic              tap_first, tap_last, tap_ok, x_last, y_last;
  logic              take_max, pass_end, last_pass;
  logic [PIX_W-1:0]  v_in, cmp_out;

  assign w16       = ADDR_W'(width_i);
  assign tap_first = (dy_q == TAP_LO) && (dx_q == TAP_LO);
  assign tap_last  = (dy_q == TAP_HI) && (dx_q == TAP_HI);
  assign x_last    = (DIM_W'(x_q) + DIM_W'(1)) == width_i;
  assign y_last    = (DIM_W'(y_q) + DIM_W'(1)) == height_i;

  always_comb begin
    case (dy_q)
      TAP_LO:  row_sel = row_q - w16;
      TAP_MID: row_sel = row_q;
      default: row_sel = row_q + w16;
    endcase
  end

  // column offset of -1/0/+1 folded in as dx - 1
  assign tap_addr = row_sel + ADDR_W'(x_q) + ADDR_W'(dx_q) - ADDR_W'(1);

  // window positions outside the frame read as zero
  assign tap_ok = ((dy_q != TAP_LO) || (y_q != '0)) &&
                  ((dy_q != TAP_HI) || !y_last) &&
                  ((dx_q != TAP_LO) || (x_q != '0)) &&
                  ((dx_q != TAP_HI) || !x_last);

  // erosion first, dilation once no erode passes are left
  assign take_max  = (erode_left_q == '0);
  assign v_in      = tapv_q ? src_rdata_i : PIX_ZERO;
  assign cmp_out   = take_max ? ((v_in > acc_q) ? v_in : acc_q)
                              : ((v_in < acc_q) ? v_in : acc_q);

  assign last_pass = ((erode_left_q == PASS_W'(1)) && (dilate_left_q == '0)) ||
                     ((erode_left_q == '0) && (dilate_left_q == PASS_W'(1)));

  always_comb begin
    state_d       = state_q;
    x_d           = x_q;
    y_d           = y_q;
    row_d         = row_q;
    dx_d          = dx_q;
    dy_d          = dy_q;
    acc_d         = acc_q;
    tapv_d        = tapv_q;
    erode_left_d  = erode_left_q;
    dilate_left_d = dilate_left_q;
    pass_end      = 1'b0;
    req_o         = '0;
    req_o.raddr   = tap_addr;
    req_o.waddr   = row_q + ADDR_W'(x_q);
    req_o.wdata   = cmp_out;
    stat_o        = '0;
    stat_o.busy   = (state_q != ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          x_d           = '0;
          y_d           = '0;
          row_d         = '0;
          dx_d          = TAP_LO;
          dy_d          = TAP_LO;
          erode_left_d  = erode_passes_i;
          dilate_left_d = dilate_passes_i;
          state_d       = ST_FETCH;
        end
      end
      ST_FETCH: begin
        req_o.re = tap_ok;
        tapv_d   = tap_ok;
        if (tap_first) begin
          acc_d = take_max ? PIX_ZERO : PIX_FULL;
        end else begin
          acc_d = cmp_out;
        end
        if (tap_last) begin
          dx_d    = TAP_LO;
          dy_d    = TAP_LO;
          state_d = ST_WRITE;
        end else if (dx_q == TAP_HI) begin
          dx_d = TAP_LO;
          dy_d = dy_q + 2'd1;
        end else begin
          dx_d = dx_q + 2'd1;
        end
      end
      ST_WRITE: begin
        req_o.we = 1'b1;
        state_d  = ST_FETCH;
        if (x_last) begin
          x_d = '0;
          if (y_last) begin
            y_d      = '0;
            row_d    = '0;
            pass_end = 1'b1;
          end else begin
            y_d   = y_q + YW'(1);
            row_d = row_q + w16;
          end
        end else begin
          x_d = x_q + XW'(1);
        end
        if (pass_end) begin
          stat_o.pass_done = 1'b1;
          if (erode_left_q != '0) begin
            erode_left_d = erode_left_q - PASS_W'(1);
          end else begin
            dilate_left_d = dilate_left_q - PASS_W'(1);
          end
          if (last_pass) begin
            stat_o.run_done = 1'b1;
            state_d         = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q           <= '0;
      y_q           <= '0;
      row_q         <= '0;
      dx_q          <= TAP_LO;
      dy_q          <= TAP_LO;
      tapv_q        <= 1'b0;
      erode_left_q  <= '0;
      dilate_left_q <= '0;
    end else begin
      x_q           <= x_d;
      y_q           <= y_d;
      row_q         <= row_d;
      dx_q          <= dx_d;
      dy_q          <= dy_d;
      tapv_q        <= tapv_d;
      erode_left_q  <= erode_left_d;
      dilate_left_q <= dilate_left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

endmodule

// ----- hw/rtl/grayscale_morph_open_3x3.sv -----
// Top level of the grayscale 3x3 opening engine: command decode, stores, result path.
//
// An item is taken when start is high and busy is low. Pixel writes, pixel
// reads and unused commands may follow one another back to back; their
// result passes through stage 1 and the output register before it strobes
// on result_valid_o. A run command holds busy high while it runs its passes
// (nine window fetches and one write per pixel, all through the single read
// port of the source store and one shared min/max comparator), erode passes
// first, then dilate passes; its result takes the same path once the last
// pixel of the last pass is written. A run with nothing to do (empty frame
// or no passes) answers like a write. The receiver cannot hold results off:
// each strobe lasts exactly one cycle and must be taken then. The two frame
// stores come up undefined; no clearing pass is run, so every pixel must be
// written before a run or a read. Width and height above 256 are clipped to
// 256. Configuration may be changed only while the block is idle.
module grayscale_morph_open_3x3 import gmo_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // command channel
  input  logic              start,
  output logic              busy,
  input  gmo_item_t         item_i,
  // result channel
  output logic              result_valid_o,
  output gmo_result_t       result_o,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  gmo_cfg_t      cfg;
  gmo_mem_req_t  eng_req;
  gmo_eng_stat_t eng_stat;

  logic [DIM_W-1:0]  eff_w, eff_h;
  logic [SIZE_W-1:0] frame_size;
  logic              in_range, accept, has_work, run_go;
  logic              is_write, is_run, is_read, host_we, host_re;

  // current_is_work: 0 = image store holds the frame, 1 = work store
  logic              cur_q, cur_d;

  logic              img_we, img_re, wrk_we, wrk_re;
  logic [ADDR_W-1:0] st_waddr, st_raddr;
  logic [PIX_W-1:0]  st_wdata, img_rdata, wrk_rdata, src_rdata;

  // one stage between acceptance and the output register
  logic              s1_valid_q, s1_valid_d;
  logic              s1_read_q, s1_read_d;
  logic              s1_status_q, s1_status_d;
  logic              s1_bank_q, s1_bank_d;
  logic              res_valid_q;
  gmo_result_t       res_q, res_d;

  gmo_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // clip geometry to the store size
  assign eff_w = (cfg.frame_width > DIM_LIMIT_W) ? DIM_LIMIT_W : cfg.frame_width;
  assign eff_h = (cfg.frame_height > DIM_LIMIT_H) ? DIM_LIMIT_H : cfg.frame_height;
  assign frame_size = SIZE_W'(eff_w) * SIZE_W'(eff_h);
  assign in_range   = SIZE_W'(item_i.pixel_index) < frame_size;

  assign accept   = start && !busy;
  assign is_write = (item_i.cmd == CMD_WRITE);
  assign is_run   = (item_i.cmd == CMD_RUN);
  assign is_read  = (item_i.cmd == CMD_READ);
  assign has_work = (frame_size != '0) &&
                    ((cfg.erode_passes != '0) || (cfg.dilate_passes != '0));
  assign run_go   = accept && is_run && has_work;
  assign host_we  = accept && is_write && in_range;
  assign host_re  = accept && is_read && in_range;

  gmo_engine u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (run_go),
    .erode_passes_i  (cfg.erode_passes),
    .dilate_passes_i (cfg.dilate_passes),
    .width_i         (eff_w),
    .height_i        (eff_h),
    .src_rdata_i     (src_rdata),
    .req_o           (eng_req),
    .stat_o          (eng_stat)
  );

  assign busy = eng_stat.busy;

  // Store steering. While a run is in progress the engine reads the current
  // store and writes the other one; otherwise host items go to the current one.
  always_comb begin
    if (busy) begin
      st_waddr = eng_req.waddr;
      st_wdata = eng_req.wdata;
      st_raddr = eng_req.raddr;
      img_we   = eng_req.we && cur_q;
      wrk_we   = eng_req.we && !cur_q;
      img_re   = eng_req.re && !cur_q;
      wrk_re   = eng_req.re && cur_q;
    end else begin
      st_waddr = item_i.pixel_index;
      st_wdata = item_i.write_value;
      st_raddr = item_i.pixel_index;
      img_we   = host_we && !cur_q;
      wrk_we   = host_we && cur_q;
      img_re   = host_re && !cur_q;
      wrk_re   = host_re && cur_q;
    end
  end

  gmo_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_image_store (
    .clk_i   (clk_i),
    .we_i    (img_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (img_re),
    .raddr_i (st_raddr),
    .rdata_o (img_rdata)
  );

  gmo_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_work_store (
    .clk_i   (clk_i),
    .we_i    (wrk_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (wrk_re),
    .raddr_i (st_raddr),
    .rdata_o (wrk_rdata)
  );

  assign src_rdata = cur_q ? wrk_rdata : img_rdata;

  // each finished pass swaps source and destination
  assign cur_d = eng_stat.pass_done ? !cur_q : cur_q;

  // Every item except a run with work enters stage 1 at acceptance; a run
  // enters it when its last pass completes.
  assign s1_valid_d  = (accept && !run_go) || eng_stat.run_done;
  assign s1_read_d   = host_re;
  assign s1_status_d = accept && (is_write || is_read) && !in_range;
  assign s1_bank_d   = cur_q;

  always_comb begin
    res_d.status     = s1_status_q;
    res_d.read_value = PIX_ZERO;
    if (s1_read_q) begin
      res_d.read_value = s1_bank_q ? wrk_rdata : img_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= 1'b0;
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      cur_q       <= cur_d;
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_read_q   <= s1_read_d;
    s1_status_q <= s1_status_d;
    s1_bank_q   <= s1_bank_d;
    res_q       <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // a run with work must raise busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_go |=> busy)
    else $error("run accepted but engine did not start");

  // nothing enters the result path while a run is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> !busy)
    else $error("result staged while engine busy");

  // finishing a pass swaps the current store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_stat.pass_done |=> (cur_q != $past(cur_q)))
    else $error("store swap missing after pass");

  // an out-of-frame index never returns pixel data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status) |-> (result_o.read_value == PIX_ZERO))
    else $error("flagged result carries data");

endmodule
